/* design/nsc_pkg.sv */
// Shared types, character codes and lookup functions for the NMEA sentence checker.
package nsc_pkg;

  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam int unsigned MIN_SENT_LEN = 6;
  localparam int unsigned SUM_CHARS    = 2;

  typedef enum logic [2:0] {
    EV_GGA_OK   = 3'd0,
    EV_RMC_OK   = 3'd1,
    EV_SUM_FAIL = 3'd2,
    EV_OTHER    = 3'd3,
    EV_OVERFLOW = 3'd4,
    EV_LINE_ERR = 3'd5
  } evt_t;

  typedef struct packed {
    evt_t       ev;
    logic [8:0] len;
    logic [7:0] csum;
    logic [7:0] rsum;
    logic       last;
  } res_t;

  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } step_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } hex_t;

  function automatic logic [7:0] gga_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = 8'h24;
      3'd1:    c = 8'h47;
      3'd2:    c = 8'h50;
      3'd3:    c = 8'h47;
      3'd4:    c = 8'h47;
      3'd5:    c = 8'h41;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] rmc_char(input logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = 8'h24;
      3'd1:    c = 8'h47;
      3'd2:    c = 8'h50;
      3'd3:    c = 8'h52;
      3'd4:    c = 8'h4D;
      3'd5:    c = 8'h43;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = 4'(c - 8'h30);
    end else if (c >= 8'h41 && c <= 8'h46) begin
      h.val = 4'(c - 8'h37);
    end else if (c >= 8'h61 && c <= 8'h66) begin
      h.val = 4'(c - 8'h57);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

/* design/nsc_framer.sv */
// Sentence framer: checksum, type match and event generation for one byte per cycle while adv is high.
module nsc_framer
  import nsc_pkg::*;
#(
  parameter int MAX_LEN = 511
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       adv,
  input  logic [7:0] rx_byte,
  input  logic       byte_present,
  input  logic       line_error,
  output step_t      step
);

  localparam int CNT_W = $clog2(MAX_LEN + 1);

  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       xor_r, xor_nxt;
  logic             star_r, star_nxt;
  logic [1:0]       cas_r, cas_nxt;
  logic [7:0]       hv_r, hv_nxt;
  logic             hs_r, hs_nxt;
  logic             gm_r, gm_nxt;
  logic             rm_r, rm_nxt;

  logic             byte_v;
  res_t             byte_res;
  res_t             lerr_res;
  hex_t             hd;
  logic             sum_ok;

  always_comb begin
    cnt_nxt  = cnt_r;
    xor_nxt  = xor_r;
    star_nxt = star_r;
    cas_nxt  = cas_r;
    hv_nxt   = hv_r;
    hs_nxt   = hs_r;
    gm_nxt   = gm_r;
    rm_nxt   = rm_r;
    byte_v   = 1'b0;
    byte_res = '{ev: EV_OTHER, len: 9'(cnt_r), csum: 8'd0, rsum: 8'd0, last: 1'b0};
    hd       = hex_digit(rx_byte);
    sum_ok   = star_r && (cas_r >= 2'(SUM_CHARS)) && (hv_r == xor_r);

    if (byte_present) begin
      if (cnt_r >= CNT_W'(MAX_LEN)) begin
        byte_v      = 1'b1;
        byte_res.ev = EV_OVERFLOW;
        cnt_nxt  = '0;
        xor_nxt  = 8'd0;
        star_nxt = 1'b0;
        cas_nxt  = 2'd0;
        hv_nxt   = 8'd0;
        hs_nxt   = 1'b0;
        gm_nxt   = 1'b1;
        rm_nxt   = 1'b1;
      end else if (rx_byte == CH_DOLLAR) begin
        cnt_nxt  = CNT_W'(1);
        xor_nxt  = 8'd0;
        star_nxt = 1'b0;
        cas_nxt  = 2'd0;
        hv_nxt   = 8'd0;
        hs_nxt   = 1'b0;
        gm_nxt   = 1'b1;
        rm_nxt   = 1'b1;
      end else if (rx_byte == CH_LF && cnt_r != '0) begin
        if (cnt_r >= CNT_W'(MIN_SENT_LEN)) begin
          byte_v        = 1'b1;
          byte_res.csum = xor_r;
          byte_res.rsum = hv_r;
          if (gm_r || rm_r) begin
            byte_res.ev = !sum_ok ? EV_SUM_FAIL : (gm_r ? EV_GGA_OK : EV_RMC_OK);
          end else begin
            byte_res.ev = EV_OTHER;
          end
        end
        cnt_nxt  = '0;
        xor_nxt  = 8'd0;
        star_nxt = 1'b0;
        cas_nxt  = 2'd0;
        hv_nxt   = 8'd0;
        hs_nxt   = 1'b0;
        gm_nxt   = 1'b1;
        rm_nxt   = 1'b1;
      end else if (rx_byte != CH_CR && cnt_r != '0) begin
        if (cnt_r < CNT_W'(MIN_SENT_LEN)) begin
          if (rx_byte != gga_char(cnt_r[2:0])) gm_nxt = 1'b0;
          if (rx_byte != rmc_char(cnt_r[2:0])) rm_nxt = 1'b0;
        end
        if (star_r) begin
          if (cas_r < 2'(SUM_CHARS)) begin
            if (!hs_r && hd.ok) begin
              hv_nxt = {hv_r[3:0], hd.val};
            end else begin
              hs_nxt = 1'b1;
            end
            cas_nxt = cas_r + 2'd1;
          end
        end else if (rx_byte == CH_STAR) begin
          star_nxt = 1'b1;
        end else begin
          xor_nxt = xor_r ^ rx_byte;
        end
        cnt_nxt = cnt_r + CNT_W'(1);
      end
    end

    lerr_res = '{ev: EV_LINE_ERR, len: 9'(cnt_nxt), csum: 8'd0, rsum: 8'd0, last: 1'b1};
    if (line_error) begin
      cnt_nxt  = '0;
      xor_nxt  = 8'd0;
      star_nxt = 1'b0;
      cas_nxt  = 2'd0;
      hv_nxt   = 8'd0;
      hs_nxt   = 1'b0;
      gm_nxt   = 1'b1;
      rm_nxt   = 1'b1;
    end

    step.v0 = byte_v || line_error;
    step.v1 = byte_v && line_error;
    step.r1 = lerr_res;
    if (byte_v) begin
      step.r0      = byte_res;
      step.r0.last = !line_error;
    end else begin
      step.r0 = lerr_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      xor_r  <= 8'd0;
      star_r <= 1'b0;
      cas_r  <= 2'd0;
      hv_r   <= 8'd0;
      hs_r   <= 1'b0;
      gm_r   <= 1'b1;
      rm_r   <= 1'b1;
    end else if (adv) begin
      cnt_r  <= cnt_nxt;
      xor_r  <= xor_nxt;
      star_r <= star_nxt;
      cas_r  <= cas_nxt;
      hv_r   <= hv_nxt;
      hs_r   <= hs_nxt;
      gm_r   <= gm_nxt;
      rm_r   <= rm_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_LEN))
    else $error("stored count beyond buffer limit");

  a_cas_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cas_r <= 2'(SUM_CHARS))
    else $error("checksum character count beyond two");

  a_hex_after_star: assert property (@(posedge clk) disable iff (!rst_n)
    (cas_r != 2'd0 || hs_r) |-> star_r)
    else $error("checksum digits tracked without a star");
`endif

endmodule

/* design/nsc_out_buf.sv */
// Two-slot result buffer that sends up to two results of one input in order.
module nsc_out_buf
  import nsc_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  load,
  input  step_t step,
  output logic  free,
  output logic  out_valid,
  input  logic  out_ready,
  output res_t  head
);

  res_t slot0_r, slot0_nxt;
  res_t slot1_r, slot1_nxt;
  logic valid_r, valid_nxt;
  logic has2_r, has2_nxt;

  assign free      = !valid_r || (out_ready && !has2_r);
  assign out_valid = valid_r;
  assign head      = slot0_r;

  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    valid_nxt = valid_r;
    has2_nxt  = has2_r;
    if (load) begin
      slot0_nxt = step.r0;
      slot1_nxt = step.r1;
      valid_nxt = 1'b1;
      has2_nxt  = step.v1;
    end else if (valid_r && out_ready) begin
      if (has2_r) begin
        slot0_nxt = slot1_r;
        has2_nxt  = 1'b0;
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      has2_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      has2_r  <= has2_nxt;
    end
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

`ifndef SYNTHESIS
  a_has2_valid: assert property (@(posedge clk) disable iff (!rst_n)
    has2_r |-> valid_r)
    else $error("second slot held without a valid head");

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> free)
    else $error("result loaded into a busy buffer");

  a_load_fills: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> valid_r && (has2_r == $past(step.v1)))
    else $error("loaded results not held");
`endif

endmodule

/* design/nmea_sentence_checker.sv */
// NMEA sentence checker top level: input register, framer and result buffer.
// A result passes through the input register and then the result buffer before it is presented.
// Throughput: one input per cycle while the result buffer is free; inputs with no result never wait on the output.
// An input with two results occupies the result buffer for two output transfers.
// Reset (synchronous, rst_n low) empties both stages and clears the framer state.
module nmea_sentence_checker
  import nsc_pkg::*;
#(
  parameter int MAX_LEN = 511
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  input  logic       in_byte_present,
  input  logic       in_line_error,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_event_res,
  output logic [8:0] out_sentence_length,
  output logic [7:0] out_computed_sum,
  output logic [7:0] out_received_sum,
  output logic       out_last_result
);

  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_present_r;
  logic       s1_lerr_r;
  logic       s1_adv;
  logic       buf_free;
  step_t      step;
  res_t       head;

  assign s1_adv   = s1_valid_r && (!step.v0 || buf_free);
  assign in_ready = !s1_valid_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_byte_r    <= in_rx_byte;
      s1_present_r <= in_byte_present;
      s1_lerr_r    <= in_line_error;
    end
  end

  nsc_framer #(
    .MAX_LEN(MAX_LEN)
  ) u_framer (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (s1_adv),
    .rx_byte     (s1_byte_r),
    .byte_present(s1_present_r),
    .line_error  (s1_lerr_r),
    .step        (step)
  );

  nsc_out_buf u_out_buf (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (s1_adv && step.v0),
    .step     (step),
    .free     (buf_free),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .head     (head)
  );

  assign out_event_res       = head.ev;
  assign out_sentence_length = head.len;
  assign out_computed_sum    = head.csum;
  assign out_received_sum    = head.rsum;
  assign out_last_result     = head.last;

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the NMEA sentence checker: framing, overflow, random traffic.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nsc_pkg::*;

  localparam int MAX_LEN     = 511;
  localparam int ITEM_TARGET = 1950;
  localparam int IDLE_LIMIT  = 1000;
  localparam int DRAIN_WAIT  = 6;

  localparam logic [47:0] GGA_TAG = "$GPGGA";
  localparam logic [47:0] RMC_TAG = "$GPRMC";

  typedef enum int {TAG_GGA, TAG_RMC, TAG_NEAR, TAG_OTHER} tag_kind_t;
  typedef enum int {SUM_GOOD, SUM_BAD, SUM_NONE, SUM_SHORT, SUM_JUNK, SUM_PARTIAL} sum_mode_t;
  typedef enum int {RDY_OPEN, RDY_BUSY, RDY_STARVED, RDY_PERIODIC} rdy_mode_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_rx_byte = 8'h00;
  logic       in_byte_present = 1'b0;
  logic       in_line_error = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [2:0] out_event_res;
  logic [8:0] out_sentence_length;
  logic [7:0] out_computed_sum;
  logic [7:0] out_received_sum;
  logic       out_last_result;

  nmea_sentence_checker #(.MAX_LEN(MAX_LEN)) u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .in_byte_present     (in_byte_present),
    .in_line_error       (in_line_error),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_event_res       (out_event_res),
    .out_sentence_length (out_sentence_length),
    .out_computed_sum    (out_computed_sum),
    .out_received_sum    (out_received_sum),
    .out_last_result     (out_last_result)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Framer model state
  int unsigned fr_count;
  logic [7:0]  fr_xor;
  bit          fr_star;
  int unsigned fr_after;
  logic [7:0]  fr_hex;
  bit          fr_hstop;
  bit          fr_gga;
  bit          fr_rmc;

  res_t        expected_q[$];
  res_t        want_r;
  int          mismatch_cnt = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  int          sent_items = 0;
  logic [7:0]  line_q[$];
  rdy_mode_t   rdy_mode = RDY_OPEN;
  int          rdy_left = 0;

  function void framer_clear();
    fr_count = 0;
    fr_xor   = 8'h00;
    fr_star  = 1'b0;
    fr_after = 0;
    fr_hex   = 8'h00;
    fr_hstop = 1'b0;
    fr_gga   = 1'b1;
    fr_rmc   = 1'b1;
  endfunction

  function automatic int nibble_of(logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h37;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h57;
    return -1;
  endfunction

  function automatic void framer_store(logic [7:0] c);
    int d;
    if (fr_count < 6) begin
      if (c != GGA_TAG[8*(5-fr_count) +: 8]) fr_gga = 1'b0;
      if (c != RMC_TAG[8*(5-fr_count) +: 8]) fr_rmc = 1'b0;
    end
    if (fr_star) begin
      if (fr_after < SUM_CHARS) begin
        d = nibble_of(c);
        if (!fr_hstop && d >= 0) fr_hex = {fr_hex[3:0], 4'(d)};
        else fr_hstop = 1'b1;
        fr_after++;
      end
    end else if (fr_count > 0) begin
      if (c == CH_STAR) fr_star = 1'b1;
      else fr_xor ^= c;
    end
    fr_count++;
  endfunction

  function automatic res_t make_result(evt_t ev, int unsigned len, logic [7:0] cs,
                                       logic [7:0] rs);
    res_t r;
    r.ev   = ev;
    r.len  = len[8:0];
    r.csum = cs;
    r.rsum = rs;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic void predict_transfer(logic [7:0] c, logic present, logic lerr);
    res_t pend[2];
    int   n;
    evt_t ev;
    n = 0;
    if (present) begin
      if (fr_count >= MAX_LEN) begin
        pend[n] = make_result(EV_OVERFLOW, fr_count, 8'h00, 8'h00);
        n++;
        framer_clear();
      end else if (c == CH_DOLLAR) begin
        framer_clear();
        framer_store(c);
      end else if (c == CH_LF && fr_count > 0) begin
        if (fr_count >= MIN_SENT_LEN) begin
          if (fr_gga || fr_rmc) begin
            if (fr_star && fr_after >= SUM_CHARS && fr_hex == fr_xor) begin
              if (fr_gga) ev = EV_GGA_OK;
              else ev = EV_RMC_OK;
            end else begin
              ev = EV_SUM_FAIL;
            end
          end else begin
            ev = EV_OTHER;
          end
          pend[n] = make_result(ev, fr_count, fr_xor, fr_hex);
          n++;
        end
        framer_clear();
      end else if (c != CH_CR && fr_count > 0) begin
        framer_store(c);
      end
    end
    if (lerr) begin
      pend[n] = make_result(EV_LINE_ERR, fr_count, 8'h00, 8'h00);
      n++;
      framer_clear();
    end
    if (n > 0) pend[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_q.push_back(pend[i]);
  endfunction

  function automatic void cmp_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // Result checker, input predictor and watchdog
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with none expected, expected none, actual event %0d",
                   $time, out_event_res);
          mismatch_cnt++;
        end else begin
          want_r = expected_q.pop_front();
          cmp_field("event_res", want_r.ev, out_event_res);
          cmp_field("sentence_length", want_r.len, out_sentence_length);
          cmp_field("computed_sum", want_r.csum, out_computed_sum);
          cmp_field("received_sum", want_r.rsum, out_received_sum);
          cmp_field("last_result", want_r.last, out_last_result);
        end
      end
      if (in_valid && in_ready) begin
        predict_transfer(in_rx_byte, in_byte_present, in_line_error);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  // Receiver stall pattern
  always @(posedge clk) begin
    if (rdy_left == 0) begin
      rdy_mode = rdy_mode_t'($urandom_range(0, 3));
      rdy_left = $urandom_range(20, 300);
    end else begin
      rdy_left--;
    end
    case (rdy_mode)
      RDY_OPEN:    out_ready <= 1'b1;
      RDY_BUSY:    out_ready <= ($urandom_range(0, 3) != 0);
      RDY_STARVED: out_ready <= ($urandom_range(0, 4) == 0);
      default:     out_ready <= ((rdy_left % 7) < 4);
    endcase
  end

  task automatic send_item(logic [7:0] b, logic present, logic lerr);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 300) :
                   $urandom_range(1, 20);
    end
    in_valid        <= 1'b1;
    in_rx_byte      <= b;
    in_byte_present <= present;
    in_line_error   <= lerr;
    do @(posedge clk); while (!in_ready);
    burst_left--;
    sent_items++;
  endtask

  task automatic wait_drained();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic queue_text(string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n, bit lower);
    if (n < 4'd10) return 8'h30 + 8'(n);
    if (lower) return 8'h57 + 8'(n);
    return 8'h37 + 8'(n);
  endfunction

  task automatic queue_sum(logic [7:0] v, bit lower);
    line_q.push_back(hex_char(v[7:4], lower));
    line_q.push_back(hex_char(v[3:0], lower));
  endtask

  function automatic logic [7:0] sum_from(int start);
    logic [7:0] x;
    x = 8'h00;
    for (int i = start + 1; i < line_q.size(); i++) begin
      if (line_q[i] == CH_STAR) break;
      x ^= line_q[i];
    end
    return x;
  endfunction

  function automatic logic [7:0] body_char();
    logic [7:0] c;
    if ($urandom_range(0, 11) == 0) begin
      do c = 8'($urandom_range(0, 255)); while (c == CH_DOLLAR || c == CH_LF || c == CH_CR);
    end else begin
      do c = 8'($urandom_range(32, 126)); while (c == CH_DOLLAR || c == CH_STAR);
    end
    return c;
  endfunction

  task automatic build_sentence(tag_kind_t kind, int body_len, sum_mode_t mode, bit crlf,
                                bit lower);
    int         start;
    int         pos;
    logic [7:0] cs;
    string      junk;
    junk  = " -+Gg,";
    start = line_q.size();
    case (kind)
      TAG_GGA: queue_text("$GPGGA");
      TAG_RMC: queue_text("$GPRMC");
      TAG_NEAR: begin
        if ($urandom_range(0, 1) == 0) queue_text("$GPGGA");
        else queue_text("$GPRMC");
        pos = $urandom_range(1, 5);
        line_q[start+pos] = line_q[start+pos] ^ 8'(1 << $urandom_range(0, 6));
      end
      default: begin
        line_q.push_back(CH_DOLLAR);
        repeat (5) line_q.push_back(8'($urandom_range(65, 90)));
      end
    endcase
    repeat (body_len) line_q.push_back(body_char());
    cs = sum_from(start);
    if (mode != SUM_NONE) line_q.push_back(CH_STAR);
    case (mode)
      SUM_GOOD: queue_sum(cs, lower);
      SUM_BAD:  queue_sum(cs ^ 8'($urandom_range(1, 255)), lower);
      SUM_SHORT: line_q.push_back(hex_char(4'($urandom_range(0, 15)), lower));
      SUM_JUNK: begin
        line_q.push_back(junk[$urandom_range(0, 5)]);
        line_q.push_back(hex_char(4'($urandom_range(0, 15)), lower));
      end
      SUM_PARTIAL: begin
        line_q.push_back(hex_char(4'($urandom_range(0, 15)), lower));
        line_q.push_back(junk[$urandom_range(0, 5)]);
      end
      default: ;
    endcase
    if (crlf) line_q.push_back(CH_CR);
    line_q.push_back(CH_LF);
  endtask

  task automatic send_line(bit noisy);
    logic lerr;
    foreach (line_q[i]) begin
      if (noisy && $urandom_range(0, 19) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      lerr = noisy && ($urandom_range(0, 249) == 0);
      send_item(line_q[i], 1'b1, lerr);
    end
    line_q.delete();
  endtask

  task automatic test_framing_cases();
    send_item("A", 1'b1, 1'b0);
    send_item(CH_LF, 1'b1, 1'b0);
    send_item(CH_DOLLAR, 1'b0, 1'b0);
    build_sentence(TAG_GGA, 3, SUM_GOOD, 1'b1, 1'b0);
    build_sentence(TAG_RMC, 0, SUM_GOOD, 1'b0, 1'b1);
    build_sentence(TAG_GGA, 2, SUM_BAD, 1'b0, 1'b0);
    build_sentence(TAG_RMC, 1, SUM_SHORT, 1'b0, 1'b0);
    build_sentence(TAG_GGA, 0, SUM_JUNK, 1'b0, 1'b1);
    build_sentence(TAG_RMC, 0, SUM_PARTIAL, 1'b0, 1'b0);
    build_sentence(TAG_GGA, 2, SUM_NONE, 1'b1, 1'b0);
    build_sentence(TAG_OTHER, 2, SUM_GOOD, 1'b0, 1'b0);
    build_sentence(TAG_NEAR, 1, SUM_GOOD, 1'b0, 1'b1);
    queue_text("$GP\n");
    queue_text("$GPG");
    build_sentence(TAG_RMC, 1, SUM_GOOD, 1'b0, 1'b0);
    send_line(1'b0);
    // NUL and 0xFF inside the checksummed part
    queue_text("$GPGGA");
    line_q.push_back(8'h00);
    line_q.push_back(8'hFF);
    line_q.push_back(CH_STAR);
    queue_sum(sum_from(0), 1'b0);
    line_q.push_back(CH_LF);
    send_line(1'b0);
    queue_text("$GPRMC,12");
    send_line(1'b0);
    send_item(8'hFF, 1'b0, 1'b1);
    build_sentence(TAG_GGA, 1, SUM_GOOD, 1'b0, 1'b0);
    void'(line_q.pop_back());
    send_line(1'b0);
    send_item(CH_LF, 1'b1, 1'b1);
    send_item(CH_DOLLAR, 1'b1, 1'b1);
    send_item(8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_buffer_overflow();
    line_q.push_back(CH_DOLLAR);
    repeat (MAX_LEN - 1) line_q.push_back(8'($urandom_range(32, 126)) == CH_DOLLAR ?
                                          8'h2C : 8'($urandom_range(48, 57)));
    send_line(1'b0);
    send_item(CH_DOLLAR, 1'b1, 1'b1);
    build_sentence(TAG_GGA, 4, SUM_GOOD, 1'b1, 1'b0);
    send_line(1'b0);
  endtask

  task automatic test_random_traffic();
    int        pick;
    int        cut;
    tag_kind_t kind;
    sum_mode_t mode;
    while (sent_items < ITEM_TARGET) begin
      pick = $urandom_range(0, 9);
      case ($urandom_range(0, 9))
        0, 1, 2: kind = TAG_GGA;
        3, 4, 5: kind = TAG_RMC;
        6:       kind = TAG_NEAR;
        default: kind = TAG_OTHER;
      endcase
      mode = ($urandom_range(0, 9) < 6) ? SUM_GOOD : sum_mode_t'($urandom_range(1, 5));
      if (pick < 8) begin
        build_sentence(kind, ($urandom_range(0, 9) == 0) ? $urandom_range(20, 70) :
                       $urandom_range(0, 15), mode, $urandom_range(0, 1), $urandom_range(0, 1));
        send_line(1'b1);
      end else if (pick == 8) begin
        repeat ($urandom_range(1, 6)) begin
          send_item(8'($urandom_range(0, 255)), ($urandom_range(0, 3) != 0),
                    ($urandom_range(0, 15) == 0));
        end
      end else begin
        build_sentence(kind, $urandom_range(0, 10), mode, 1'b0, $urandom_range(0, 1));
        cut = $urandom_range(1, line_q.size() - 1);
        while (line_q.size() > cut) void'(line_q.pop_back());
        send_line(1'b1);
      end
    end
  endtask

  initial begin
    framer_clear();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_framing_cases();
    wait_drained();
    test_buffer_overflow();
    wait_drained();
    test_random_traffic();
    wait_drained();
    if (mismatch_cnt == 0 && expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
